// File: rtl/core/srb_pkg.sv
// srb_pkg: shared types and constants for the sequence reorder buffer
// used by srb_cell and sequence_reorder_buffer_core; no dependencies
package srb_pkg;

  localparam int SEQ_W         = 32;
  localparam int HANDLE_PORT_W = 16;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 48;

  localparam logic ACT_FORWARD = 1'b0;
  localparam logic ACT_DROP    = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_REPLACE
  } cell_op_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    cell_op_t         op;
    logic [SEQ_W-1:0] seq;
  } cell_cmd_t;

  // per-cell status seen by the controller and the right-hand neighbour
  typedef struct packed {
    logic valid;
    logic behind;
    logic match;
  } cell_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EVAL    = 4'b0010,
    ST_JUMP    = 4'b0100,
    ST_RELEASE = 4'b1000
  } state_t;

endpackage

// File: rtl/core/srb_cell.sv
// srb_cell: one slot of the sorted holding row (valid, sequence number, handle)
// depends on srb_pkg; neighbours hand entries left on pop and right on insert
module srb_cell #(
  parameter int HANDLE_W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srb_pkg::cell_cmd_t         cmd,
  input  logic [HANDLE_W-1:0]        cmd_handle,
  input  logic                       left_valid,
  input  logic [srb_pkg::SEQ_W-1:0]  left_seq,
  input  logic [HANDLE_W-1:0]        left_handle,
  input  logic                       left_behind,
  input  logic                       right_valid,
  input  logic [srb_pkg::SEQ_W-1:0]  right_seq,
  input  logic [HANDLE_W-1:0]        right_handle,
  output srb_pkg::cell_stat_t        stat,
  output logic [srb_pkg::SEQ_W-1:0]  seq_o,
  output logic [HANDLE_W-1:0]        handle_o
);

  logic                      valid_r, valid_nxt;
  logic [srb_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [HANDLE_W-1:0]       handle_r, handle_nxt;
  logic                      behind;
  logic                      match;

  // new number belongs at or before this slot
  assign behind = !valid_r || (seq_r > cmd.seq);
  assign match  = valid_r && (seq_r == cmd.seq);

  assign stat     = '{valid: valid_r, behind: behind, match: match};
  assign seq_o    = seq_r;
  assign handle_o = handle_r;

  always_comb begin
    valid_nxt  = valid_r;
    seq_nxt    = seq_r;
    handle_nxt = handle_r;
    unique case (cmd.op)
      srb_pkg::CELL_HOLD: begin
      end
      srb_pkg::CELL_INSERT: begin
        if (behind && left_behind) begin
          valid_nxt  = left_valid;
          seq_nxt    = left_seq;
          handle_nxt = left_handle;
        end else if (behind) begin
          valid_nxt  = 1'b1;
          seq_nxt    = cmd.seq;
          handle_nxt = cmd_handle;
        end
      end
      srb_pkg::CELL_POP: begin
        valid_nxt  = right_valid;
        seq_nxt    = right_seq;
        handle_nxt = right_handle;
      end
      srb_pkg::CELL_REPLACE: begin
        if (match) begin
          handle_nxt = cmd_handle;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r    <= seq_nxt;
    handle_r <= handle_nxt;
  end

endmodule

// File: rtl/core/sequence_reorder_buffer_core.sv
// sequence_reorder_buffer_core: an input beat is registered, then evaluated in ST_EVAL and answered there;
// an overflow inserts, goes through ST_JUMP and then releases held packets from ST_RELEASE
// the row pops one held packet per cycle while the result output is free; result back-pressure stalls it
// a new input beat is taken only once the fsm is back in ST_IDLE; no result beat for a packet that is only held
// reset: synchronous active low, clears valid bits, next expected number and the fsm
// depends on srb_pkg and srb_cell
module sequence_reorder_buffer_core #(
  parameter int HOLD_LIMIT  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srb_pkg::IN_DATA_W-1:0]     in_tdata,   // seq_number[31:0], packet_handle[47:32]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [srb_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_handle[15:0], out_seq[47:16]
  output logic                              out_tuser,  // action
  output logic                              out_tlast
);

  localparam int SLOTS = HOLD_LIMIT + 1;
  localparam int HW    = (HANDLE_BITS < srb_pkg::HANDLE_PORT_W) ? HANDLE_BITS
                                                                 : srb_pkg::HANDLE_PORT_W;
  localparam int SW    = srb_pkg::SEQ_W;
  localparam int PW    = srb_pkg::HANDLE_PORT_W;

  srb_pkg::state_t   state_r, state_nxt;
  logic [SW-1:0]     ne_r, ne_nxt;
  logic [SW-1:0]     ne_inc;
  logic [SW-1:0]     seq_r;
  logic [HW-1:0]     hdl_r;

  srb_pkg::cell_cmd_t  cmd;
  srb_pkg::cell_op_t   cmd_op;
  srb_pkg::cell_stat_t st [SLOTS];
  logic [SLOTS-1:0]    cv;
  logic [SW-1:0]       cs [SLOTS];
  logic [HW-1:0]       ch [SLOTS];

  logic [SLOTS-1:0]    left_valid, left_behind, right_valid;
  logic [SW-1:0]       left_seq [SLOTS];
  logic [SW-1:0]       right_seq [SLOTS];
  logic [HW-1:0]       left_handle [SLOTS];
  logic [HW-1:0]       right_handle [SLOTS];

  logic                any_match;
  logic [HW-1:0]       match_handle;
  logic                is_eq, is_lt, out_free;

  logic                emit;
  logic [PW-1:0]       em_handle;
  logic [SW-1:0]       em_seq;
  logic                em_act, em_last;

  logic                out_valid_r;
  logic [PW-1:0]       out_handle_r;
  logic [SW-1:0]       out_seq_r;
  logic                out_act_r, out_last_r;

  assign in_tready  = (state_r == srb_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_seq_r, out_handle_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

  assign cmd = '{op: cmd_op, seq: seq_r};

  // neighbour wiring: the row ends read as empty
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cv[i] = st[i].valid;
      if (i == 0) begin
        left_valid[i]  = 1'b0;
        left_seq[i]    = '0;
        left_handle[i] = '0;
        left_behind[i] = 1'b0;
      end else begin
        left_valid[i]  = st[i-1].valid;
        left_seq[i]    = cs[i-1];
        left_handle[i] = ch[i-1];
        left_behind[i] = st[i-1].behind;
      end
      if (i == SLOTS - 1) begin
        right_valid[i]  = 1'b0;
        right_seq[i]    = '0;
        right_handle[i] = '0;
      end else begin
        right_valid[i]  = st[i+1].valid;
        right_seq[i]    = cs[i+1];
        right_handle[i] = ch[i+1];
      end
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    srb_cell #(
      .HANDLE_W (HW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .cmd_handle   (hdl_r),
      .left_valid   (left_valid[g]),
      .left_seq     (left_seq[g]),
      .left_handle  (left_handle[g]),
      .left_behind  (left_behind[g]),
      .right_valid  (right_valid[g]),
      .right_seq    (right_seq[g]),
      .right_handle (right_handle[g]),
      .stat         (st[g]),
      .seq_o        (cs[g]),
      .handle_o     (ch[g])
    );
  end

  always_comb begin
    any_match    = 1'b0;
    match_handle = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_match    = any_match | st[i].match;
      match_handle = match_handle | (st[i].match ? ch[i] : '0);
    end
  end

  assign ne_inc   = ne_r + SW'(1);
  assign is_eq    = (seq_r == ne_r);
  assign is_lt    = (seq_r < ne_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    ne_nxt    = ne_r;
    cmd_op    = srb_pkg::CELL_HOLD;
    emit      = 1'b0;
    em_handle = '0;
    em_seq    = '0;
    em_act    = srb_pkg::ACT_FORWARD;
    em_last   = 1'b0;
    unique case (state_r)
      srb_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = srb_pkg::ST_EVAL;
        end
      end
      srb_pkg::ST_EVAL: begin
        priority if (is_eq) begin
          if (out_free) begin
            emit      = 1'b1;
            em_handle = PW'(hdl_r);
            em_seq    = seq_r;
            em_act    = srb_pkg::ACT_FORWARD;
            em_last   = !(cv[0] && (cs[0] == ne_inc));
            ne_nxt    = ne_inc;
            state_nxt = em_last ? srb_pkg::ST_IDLE : srb_pkg::ST_RELEASE;
          end
        end else if (is_lt) begin
          if (out_free) begin
            emit      = 1'b1;
            em_handle = PW'(hdl_r);
            em_seq    = seq_r;
            em_act    = srb_pkg::ACT_DROP;
            em_last   = 1'b1;
            state_nxt = srb_pkg::ST_IDLE;
          end
        end else if (any_match) begin
          if (out_free) begin
            emit      = 1'b1;
            em_handle = PW'(match_handle);
            em_seq    = seq_r;
            em_act    = srb_pkg::ACT_DROP;
            em_last   = 1'b1;
            cmd_op    = srb_pkg::CELL_REPLACE;
            state_nxt = srb_pkg::ST_IDLE;
          end
        end else begin
          // row holds at most HOLD_LIMIT here, so the insert never loses an entry
          cmd_op    = srb_pkg::CELL_INSERT;
          state_nxt = cv[SLOTS-2] ? srb_pkg::ST_JUMP : srb_pkg::ST_IDLE;
        end
      end
      srb_pkg::ST_JUMP: begin
        // row is sorted, so the smallest held number sits in the first cell
        ne_nxt    = cs[0];
        state_nxt = srb_pkg::ST_RELEASE;
      end
      srb_pkg::ST_RELEASE: begin
        if (out_free) begin
          emit      = 1'b1;
          em_handle = PW'(ch[0]);
          em_seq    = cs[0];
          em_act    = srb_pkg::ACT_FORWARD;
          em_last   = !(cv[1] && (cs[1] == ne_inc));
          cmd_op    = srb_pkg::CELL_POP;
          ne_nxt    = ne_inc;
          state_nxt = em_last ? srb_pkg::ST_IDLE : srb_pkg::ST_RELEASE;
        end
      end
      default: begin
        state_nxt = srb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srb_pkg::ST_IDLE;
      ne_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ne_r    <= ne_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      seq_r <= in_tdata[SW-1:0];
      hdl_r <= in_tdata[SW +: HW];
    end
    if (emit) begin
      out_handle_r <= em_handle;
      out_seq_r    <= em_seq;
      out_act_r    <= em_act;
      out_last_r   <= em_last;
    end
  end

`ifndef ASSERT_OFF
  // valid entries stay packed towards the first cell
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cv & (cv + SLOTS'(1))) == '0)
    else $error("holding row not packed");

  // between items the row never holds more than the limit
  a_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srb_pkg::ST_IDLE) |-> !cv[SLOTS-1])
    else $error("holding row full while idle");

  // a release step always finds the expected number at the head
  a_release_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srb_pkg::ST_RELEASE) |-> (cv[0] && (cs[0] == ne_r)))
    else $error("release without matching head entry");

  // while idle, the head of the row is below the second entry
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == srb_pkg::ST_IDLE) && cv[1]) |-> (cs[1] > cs[0]))
    else $error("holding row out of order");
`endif

endmodule
